FILE: rtl/core/rpa_pkg.sv
package rpa_pkg;

    // Default sizing
    localparam int PAGES_DEF      = 1024;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths
    localparam int PAGE_W     = 10;
    localparam int TOP_W      = 11;
    localparam int COUNT_W    = 16;
    localparam int FREE_W     = 11;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INC   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEC   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT   = 2'd3;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_LOWEST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 1'b1;
    localparam logic [PAGE_W-1:0]    LOWEST_RST = 10'd0;
    localparam logic [TOP_W-1:0]     TOP_RST    = 11'd1024;

endpackage

FILE: rtl/core/rpa_ref_store.sv
module rpa_ref_store #(
    parameter int PAGES      = rpa_pkg::PAGES_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF,
    localparam int AW        = $clog2(PAGES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [COUNT_BITS-1:0] rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [COUNT_BITS-1:0] wr_data,
    output logic                  busy
);

    logic [COUNT_BITS-1:0] cnt_mem [PAGES];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  clr_active_reg;
    logic [AW-1:0]         clr_addr_reg;

    // Sweep the count store to zero after reset, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(PAGES - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Single write port, registered read
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            cnt_mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            cnt_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= cnt_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

FILE: rtl/core/refcounted_page_allocator_core.sv
// Reference-counted page allocator with a LIFO free list.
// Configuration: cfg_we/cfg_index/cfg_data write lowest_page (index 0) and
// top_page (index 1); write only while the block is idle.
// Input channel: in_valid/in_ready carries one command beat (cmd, page_index).
// Output channel: out_valid/out_ready carries one result beat per command
// (page_out, ref_count, free_pages, status).
// Result: the result is registered on the edge after the command is taken,
// or later still while a result waits.
// Ordering: one command at a time; the count and link memories are read on
// the accepting edge and written back when the command completes, and the
// list head must settle before the next command reads it.
// Reset: control state clears at once, then the count memory is swept to zero
// while in_ready stays low; configuration writes are still taken. The free
// list starts empty.
// Stall: a new command is taken while a result waits; that command then holds
// in the EXEC state until the output register is free, with no state
// written, so nothing is lost or repeated.
module refcounted_page_allocator_core #(
    parameter int PAGES      = rpa_pkg::PAGES_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rpa_pkg::CMD_W-1:0]       cmd,
    input  logic [rpa_pkg::PAGE_W-1:0]      page_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rpa_pkg::PAGE_W-1:0]      page_out,
    output logic [rpa_pkg::COUNT_W-1:0]     ref_count,
    output logic [rpa_pkg::FREE_W-1:0]      free_pages,
    output logic [rpa_pkg::STATUS_W-1:0]    status
);

    localparam int AW   = $clog2(PAGES);
    localparam int FT_W = $clog2(PAGES + 1);
    localparam int AXW  = (AW > rpa_pkg::PAGE_W) ? AW : rpa_pkg::PAGE_W;
    localparam int FXW  = (FT_W > rpa_pkg::FREE_W) ? FT_W : rpa_pkg::FREE_W;
    localparam int CXW  = (COUNT_BITS > rpa_pkg::COUNT_W) ? COUNT_BITS : rpa_pkg::COUNT_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [FT_W-1:0]       FT_FULL = FT_W'(PAGES);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t                          state_reg;
    logic [rpa_pkg::PAGE_W-1:0]      lowest_reg;
    logic [rpa_pkg::TOP_W-1:0]       top_reg;
    logic [rpa_pkg::PAGE_W-1:0]      head_reg, head_next;
    logic                            empty_reg, empty_next;
    logic [FT_W-1:0]                 free_total_reg, free_total_next;
    logic [rpa_pkg::CMD_W-1:0]       cmd_reg;
    logic [rpa_pkg::PAGE_W-1:0]      idx_reg;
    logic                            out_valid_reg;
    logic [rpa_pkg::PAGE_W-1:0]      page_out_reg, page_out_next;
    logic [rpa_pkg::COUNT_W-1:0]     ref_count_reg;
    logic [rpa_pkg::FREE_W-1:0]      free_pages_reg;
    logic [rpa_pkg::STATUS_W-1:0]    status_reg, status_next;

    logic                            accept;
    logic                            fire;
    logic                            ref_busy;
    logic [COUNT_BITS-1:0]           cnt_rd;
    logic                            cnt_we;
    logic [AW-1:0]                   cnt_waddr;
    logic [COUNT_BITS-1:0]           cnt_val;
    logic                            pop;
    logic                            push_req;
    logic                            push_ok;
    logic                            in_range;
    logic [rpa_pkg::PAGE_W-1:0]      link_mem [PAGES];
    logic [rpa_pkg::PAGE_W-1:0]      link_rd_reg;

    logic [AXW-1:0]                  in_idx_wide;
    logic [AXW-1:0]                  idx_wide;
    logic [AXW-1:0]                  head_wide;
    logic [AW-1:0]                   in_idx_addr;
    logic [AW-1:0]                   idx_addr;
    logic [AW-1:0]                   head_addr;
    logic [FXW-1:0]                  ft_wide;
    logic [CXW-1:0]                  cnt_wide;

    // Map page numbers onto memory addresses
    assign in_idx_wide = AXW'(page_index);
    assign idx_wide    = AXW'(idx_reg);
    assign head_wide   = AXW'(head_reg);
    assign in_idx_addr = in_idx_wide[AW-1:0];
    assign idx_addr    = idx_wide[AW-1:0];
    assign head_addr   = head_wide[AW-1:0];

    // Handshake
    assign in_ready = (state_reg == ST_IDLE) && !ref_busy;
    assign accept   = in_valid && in_ready;
    assign fire     = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    // Reference counts
    rpa_ref_store #(
        .PAGES      (PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_ref_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_idx_addr),
        .rd_data (cnt_rd),
        .wr_en   (fire && cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_val),
        .busy    (ref_busy)
    );

    // Link memory: read the head's successor on accept, link pushed pages
    always_ff @(posedge clk)
    begin
        if (fire && push_ok)
        begin
            link_mem[idx_addr] <= head_reg;
        end
        if (accept)
        begin
            link_rd_reg <= link_mem[head_addr];
        end
    end

    assign in_range = (idx_reg >= lowest_reg)
                   && ({1'b0, idx_reg} < top_reg)
                   && (int'(idx_reg) < PAGES);

    // Work out the command from the fetched count
    always_comb
    begin
        page_out_next = idx_reg;
        status_next   = rpa_pkg::ST_OK;
        cnt_we        = 1'b0;
        cnt_waddr     = idx_addr;
        cnt_val       = '0;
        pop           = 1'b0;
        push_req      = 1'b0;
        if (cmd_reg == rpa_pkg::CMD_ALLOC)
        begin
            if (empty_reg)
            begin
                page_out_next = '0;
                status_next   = rpa_pkg::ST_NO_FREE;
            end
            else
            begin
                pop           = 1'b1;
                page_out_next = head_reg;
                cnt_we        = 1'b1;
                cnt_waddr     = head_addr;
                cnt_val       = COUNT_BITS'(1);
            end
        end
        else if (!in_range)
        begin
            status_next = rpa_pkg::ST_RANGE;
        end
        else
        begin
            cnt_val = cnt_rd;
            case (cmd_reg)
                rpa_pkg::CMD_FREE:
                begin
                    cnt_we = 1'b1;
                    if (cnt_rd != '0)
                    begin
                        cnt_val = cnt_rd - 1'b1;
                    end
                    push_req = (cnt_val == '0);
                end
                rpa_pkg::CMD_INC:
                begin
                    cnt_we = 1'b1;
                    if (cnt_rd == CNT_MAX)
                    begin
                        status_next = rpa_pkg::ST_LIMIT;
                    end
                    else
                    begin
                        cnt_val = cnt_rd + 1'b1;
                    end
                end
                rpa_pkg::CMD_DEC:
                begin
                    cnt_we = 1'b1;
                    if (cnt_rd == '0)
                    begin
                        status_next = rpa_pkg::ST_LIMIT;
                    end
                    else
                    begin
                        cnt_val = cnt_rd - 1'b1;
                    end
                end
                rpa_pkg::CMD_ADD:
                begin
                    cnt_we   = 1'b1;
                    cnt_val  = '0;
                    push_req = 1'b1;
                end
                default:
                begin
                    cnt_val = cnt_rd;
                end
            endcase
            if (push_req && (free_total_reg == FT_FULL))
            begin
                status_next = rpa_pkg::ST_LIMIT;
            end
        end
    end

    assign push_ok = push_req && (free_total_reg != FT_FULL);

    // Advance the list head and free count
    always_comb
    begin
        head_next       = head_reg;
        free_total_next = free_total_reg;
        empty_next      = empty_reg;
        if (pop)
        begin
            head_next = link_rd_reg;
            if (free_total_reg != '0)
            begin
                free_total_next = free_total_reg - 1'b1;
            end
            empty_next = (free_total_next == '0);
        end
        else if (push_ok)
        begin
            head_next       = idx_reg;
            free_total_next = free_total_reg + 1'b1;
            empty_next      = 1'b0;
        end
    end

    assign ft_wide  = FXW'(free_total_next);
    assign cnt_wide = CXW'(cnt_val);

    // State, list registers, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lowest_reg     <= rpa_pkg::LOWEST_RST;
            top_reg        <= rpa_pkg::TOP_RST;
            head_reg       <= '0;
            empty_reg      <= 1'b1;
            free_total_reg <= '0;
            out_valid_reg  <= 1'b0;
            page_out_reg   <= '0;
            ref_count_reg  <= '0;
            free_pages_reg <= '0;
            status_reg     <= rpa_pkg::ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rpa_pkg::REG_LOWEST: lowest_reg <= cfg_data[rpa_pkg::PAGE_W-1:0];
                    rpa_pkg::REG_TOP:    top_reg    <= cfg_data;
                    default:             ;
                endcase
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (fire)
                    begin
                        state_reg      <= ST_IDLE;
                        head_reg       <= head_next;
                        empty_reg      <= empty_next;
                        free_total_reg <= free_total_next;
                        out_valid_reg  <= 1'b1;
                        page_out_reg   <= page_out_next;
                        ref_count_reg  <= (status_next == rpa_pkg::ST_RANGE
                                           || status_next == rpa_pkg::ST_NO_FREE)
                                          ? '0 : cnt_wide[rpa_pkg::COUNT_W-1:0];
                        free_pages_reg <= ft_wide[rpa_pkg::FREE_W-1:0];
                        status_reg     <= status_next;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Hold the command beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            idx_reg <= page_index;
        end
    end

    assign out_valid  = out_valid_reg;
    assign page_out   = page_out_reg;
    assign ref_count  = ref_count_reg;
    assign free_pages = free_pages_reg;
    assign status     = status_reg;

`ifndef ASSERT_OFF
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        ref_busy |-> !in_ready)
        else $error("command accepted during count memory sweep");

    a_free_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        free_total_reg <= FT_FULL)
        else $error("free page total exceeds page count");

    a_empty_matches_total: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg == (free_total_reg == '0))
        else $error("empty flag disagrees with free page total");

    a_exec_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && out_valid_reg && !out_ready) |=> (state_reg == ST_EXEC))
        else $error("command completed while result register was occupied");
`endif

endmodule
